### design/artdmx_pkg.sv
// ----------------------------------------------------------------------------
// artdmx_pkg
// Shared types and constants of the ArtDmx pixel stream parser.
// ----------------------------------------------------------------------------
package artdmx_pkg;

	// Default values for the top-level parameters.
	localparam int PIXELS_PER_UNIVERSE_DEF = 170;
	localparam int MAX_FRAME_BYTES_DEF     = 528;

	// Fixed field widths.
	localparam int BYTE_W   = 8;
	localparam int ADDR_W   = 32;
	localparam int RGB_W    = 24;
	localparam int CODE_W   = 3;
	localparam int UNIV_W   = 16;
	localparam int FLEN_W   = 10;
	localparam int PIXIDX_W = 8;
	localparam int OFFSET_W = 25;

	// Frame layout constants.
	localparam int HEADER_BYTES = 18;
	localparam int MAX_DMX      = 510;

	// Queue between the parser and the address stage.
	localparam int QUEUE_DEPTH = 4;

	// Kind of a result item.
	typedef enum logic {
		KIND_PIXEL = 1'b0,
		KIND_ERROR = 1'b1
	} kind_t;

	// Error codes reported in a result item.
	typedef enum logic [CODE_W-1:0] {
		ERR_SYNC     = 3'd0,
		ERR_OVERSIZE = 3'd1,
		ERR_ID       = 3'd2,
		ERR_OPCODE   = 3'd3,
		ERR_VERSION  = 3'd4,
		ERR_DMX_LEN  = 3'd5,
		ERR_SHORT    = 3'd6
	} err_code_t;

	// Command passed from the parser to the address stage.
	typedef struct packed {
		kind_t                 kind;
		err_code_t             code;
		logic [UNIV_W-1:0]     universe;
		logic [PIXIDX_W-1:0]   pixel_index;
		logic [RGB_W-1:0]      rgb;
	} cmd_t;

endpackage

### design/artdmx_if.sv
// ----------------------------------------------------------------------------
// artdmx_if
// Valid/ready channels for the received byte stream and the result items.
// ----------------------------------------------------------------------------
interface artdmx_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

interface artdmx_result_if;
	logic        valid;
	logic        ready;
	logic        result_kind;
	logic [31:0] write_address;
	logic [23:0] pixel_rgb;
	logic [2:0]  error_code;

	modport source (
		output valid, output result_kind, output write_address,
		output pixel_rgb, output error_code, input ready
	);
	modport sink (
		input valid, input result_kind, input write_address,
		input pixel_rgb, input error_code, output ready
	);
endinterface

### design/artdmx_front.sv
// ----------------------------------------------------------------------------
// artdmx_front
// Byte parser: sync hunt, frame length, ArtDmx header checks and pixel
// assembly. Emits one command per byte that causes a result.
// ----------------------------------------------------------------------------
module artdmx_front #(
	parameter int MAX_FRAME_BYTES = artdmx_pkg::MAX_FRAME_BYTES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	artdmx_byte_if.sink       bytes,
	input  logic              queue_full,
	output logic              cmd_push,
	output artdmx_pkg::cmd_t  cmd
);
	import artdmx_pkg::*;

	typedef enum logic [4:0] {
		PH_HUNT   = 5'b00001,
		PH_EXPECT = 5'b00010,
		PH_LEN_LO = 5'b00100,
		PH_LEN_HI = 5'b01000,
		PH_BODY   = 5'b10000
	} phase_t;

	localparam logic [BYTE_W-1:0] SYNC_N     = 8'h6E;
	localparam logic [BYTE_W-1:0] SYNC_B     = 8'h62;
	localparam logic [BYTE_W-1:0] OPCODE_HI  = 8'h50;
	localparam logic [BYTE_W-1:0] VERSION_LO = 8'd14;
	localparam logic [BYTE_W-1:0] ART_ID [8] = '{
		8'h41, 8'h72, 8'h74, 8'h2D, 8'h4E, 8'h65, 8'h74, 8'h00
	};
	// x / 3 == (x * 171) >> 9 for every x below 512.
	localparam int DIV3_MUL   = 171;
	localparam int DIV3_SHIFT = 9;

	phase_t                phase_q, phase_d;
	logic [BYTE_W-1:0]     len_lo_q, len_lo_d;
	logic [FLEN_W-1:0]     frame_length_q, frame_length_d;
	logic [FLEN_W-1:0]     byte_count_q, byte_count_d;
	logic [UNIV_W-1:0]     universe_q, universe_d;
	logic [BYTE_W-1:0]     dmx_hi_q, dmx_hi_d;
	logic [PIXIDX_W-1:0]   pix_total_q, pix_total_d;
	logic [15:0]           partial_q, partial_d;
	logic [PIXIDX_W-1:0]   pixel_index_q, pixel_index_d;
	logic [1:0]            sub_q, sub_d;
	err_code_t             first_fault_q, first_fault_d;
	logic                  fault_seen_q, fault_seen_d;

	logic                  accept;
	logic [BYTE_W-1:0]     b;
	logic [15:0]           len_full;
	logic [FLEN_W-1:0]     count_next;
	logic                  fault_hit;
	err_code_t             fault_code;
	logic                  emit;
	logic                  short_frame;
	logic [8:0]            dmx_low9;
	logic [17:0]           dmx_prod;
	logic [PIXIDX_W:0]     done_pixels;

	assign bytes.ready = !queue_full;
	assign accept      = bytes.valid && bytes.ready;
	assign b           = bytes.rx_byte;
	assign len_full    = {b, len_lo_q};
	assign count_next  = byte_count_q + 1'b1;
	assign dmx_low9    = {dmx_hi_q[0], b};
	assign dmx_prod    = 18'(dmx_low9) * 18'(DIV3_MUL);

	// Parser next state and command generation.
	always_comb begin
		phase_d        = phase_q;
		len_lo_d       = len_lo_q;
		frame_length_d = frame_length_q;
		byte_count_d   = byte_count_q;
		universe_d     = universe_q;
		dmx_hi_d       = dmx_hi_q;
		pix_total_d    = pix_total_q;
		partial_d      = partial_q;
		pixel_index_d  = pixel_index_q;
		sub_d          = sub_q;
		first_fault_d  = first_fault_q;
		fault_seen_d   = fault_seen_q;
		fault_hit      = 1'b0;
		fault_code     = ERR_ID;
		emit           = 1'b0;
		short_frame    = 1'b0;
		done_pixels    = '0;
		cmd_push       = 1'b0;
		cmd.kind       = KIND_ERROR;
		cmd.code       = ERR_SYNC;
		cmd.universe   = universe_q;
		cmd.pixel_index = pixel_index_q;
		cmd.rgb        = {b, partial_q};

		if (accept) begin
			unique case (phase_q)
				PH_HUNT: begin
					if (b == SYNC_N) begin
						phase_d = PH_EXPECT;
					end else begin
						cmd_push = 1'b1;
						cmd.code = ERR_SYNC;
					end
				end
				PH_EXPECT: begin
					if (b == SYNC_B) begin
						phase_d = PH_LEN_LO;
					end else begin
						phase_d  = PH_HUNT;
						cmd_push = 1'b1;
						cmd.code = ERR_SYNC;
					end
				end
				PH_LEN_LO: begin
					len_lo_d = b;
					phase_d  = PH_LEN_HI;
				end
				PH_LEN_HI: begin
					byte_count_d  = '0;
					universe_d    = '0;
					dmx_hi_d      = '0;
					pix_total_d   = '0;
					partial_d     = '0;
					pixel_index_d = '0;
					sub_d         = '0;
					first_fault_d = ERR_SYNC;
					fault_seen_d  = 1'b0;
					if (len_full > 16'(MAX_FRAME_BYTES)) begin
						phase_d        = PH_HUNT;
						frame_length_d = '0;
						cmd_push       = 1'b1;
						cmd.code       = ERR_OVERSIZE;
					end else if (len_full == 16'd0) begin
						phase_d        = PH_HUNT;
						frame_length_d = '0;
						cmd_push       = 1'b1;
						cmd.code       = ERR_SHORT;
					end else begin
						frame_length_d = len_full[FLEN_W-1:0];
						phase_d        = PH_BODY;
					end
				end
				PH_BODY: begin
					byte_count_d = count_next;

					// Header bytes: identifier, opcode, version, universe, length.
					if (byte_count_q < FLEN_W'(HEADER_BYTES)) begin
						if (byte_count_q < 10'd8) begin
							if (b != ART_ID[byte_count_q[2:0]]) begin
								fault_hit  = 1'b1;
								fault_code = ERR_ID;
							end
						end
						case (byte_count_q)
							10'd8: begin
								fault_hit  = (b != 8'h00);
								fault_code = ERR_OPCODE;
							end
							10'd9: begin
								fault_hit  = (b != OPCODE_HI);
								fault_code = ERR_OPCODE;
							end
							10'd10: begin
								fault_hit  = (b != 8'h00);
								fault_code = ERR_VERSION;
							end
							10'd11: begin
								fault_hit  = (b != VERSION_LO);
								fault_code = ERR_VERSION;
							end
							10'd14: universe_d = {8'h00, b};
							10'd15: universe_d = {b, universe_q[7:0]};
							10'd16: dmx_hi_d = b;
							10'd17: begin
								fault_hit   = ({dmx_hi_q, b} > 16'(MAX_DMX));
								fault_code  = ERR_DMX_LEN;
								pix_total_d = dmx_prod[DIV3_SHIFT +: PIXIDX_W];
							end
							default: ;
						endcase
					end else begin
						// Data bytes: gather three bytes per pixel.
						sub_d = (sub_q == 2'd2) ? 2'd0 : sub_q + 2'd1;
						if (!fault_seen_q && (pixel_index_q < pix_total_q)) begin
							case (sub_q)
								2'd0:    partial_d[7:0]  = b;
								2'd1:    partial_d[15:8] = b;
								default: emit = 1'b1;
							endcase
						end
					end

					// Only the first fault of a frame is kept.
					if (fault_hit && !fault_seen_q) begin
						fault_seen_d  = 1'b1;
						first_fault_d = fault_code;
					end

					// The pixel total is taken from the next state, so that a
					// frame ending on its last header byte sees the new count.
					done_pixels = {1'b0, pixel_index_q} + {{PIXIDX_W{1'b0}}, emit};
					short_frame = (count_next < FLEN_W'(HEADER_BYTES))
						|| (done_pixels < {1'b0, pix_total_d});

					if (count_next == frame_length_q) begin
						phase_d = PH_HUNT;
						if (fault_seen_d) begin
							cmd_push = 1'b1;
							cmd.code = first_fault_d;
						end else if (short_frame) begin
							cmd_push = 1'b1;
							cmd.code = ERR_SHORT;
						end else if (emit) begin
							cmd_push = 1'b1;
							cmd.kind = KIND_PIXEL;
						end
					end else if (emit) begin
						cmd_push      = 1'b1;
						cmd.kind      = KIND_PIXEL;
						pixel_index_d = pixel_index_q + 1'b1;
					end
				end
				default: phase_d = PH_HUNT;
			endcase
		end
	end

	// Parser state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_HUNT;
			len_lo_q       <= '0;
			frame_length_q <= '0;
			byte_count_q   <= '0;
			universe_q     <= '0;
			dmx_hi_q       <= '0;
			pix_total_q    <= '0;
			partial_q      <= '0;
			pixel_index_q  <= '0;
			sub_q          <= '0;
			first_fault_q  <= ERR_SYNC;
			fault_seen_q   <= 1'b0;
		end else begin
			phase_q        <= phase_d;
			len_lo_q       <= len_lo_d;
			frame_length_q <= frame_length_d;
			byte_count_q   <= byte_count_d;
			universe_q     <= universe_d;
			dmx_hi_q       <= dmx_hi_d;
			pix_total_q    <= pix_total_d;
			partial_q      <= partial_d;
			pixel_index_q  <= pixel_index_d;
			sub_q          <= sub_d;
			first_fault_q  <= first_fault_d;
			fault_seen_q   <= fault_seen_d;
		end
	end

`ifndef ASSERT_OFF
	// A command is only ever produced by an accepted byte.
	assert property (@(posedge clk) disable iff (!arst_n) cmd_push |-> accept)
		else $error("command pushed without an accepted item");

	// No pixel is written once the frame has a header fault.
	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_push && cmd.kind == KIND_PIXEL) |-> !fault_seen_q)
		else $error("pixel write issued for a faulty frame");

	// Pixel writes stay within the declared pixel count.
	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_push && cmd.kind == KIND_PIXEL) |-> (pixel_index_q < pix_total_q))
		else $error("pixel index beyond declared DMX length");
`endif

endmodule

### design/artdmx_queue.sv
// ----------------------------------------------------------------------------
// artdmx_queue
// Short first-in first-out queue of parser commands.
// ----------------------------------------------------------------------------
module artdmx_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  artdmx_pkg::cmd_t  wdata,
	input  logic              pop,
	output artdmx_pkg::cmd_t  rdata,
	output logic              full,
	output logic              empty
);
	import artdmx_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	cmd_t             mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CNT_W'(QUEUE_DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	// Storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

### design/artdmx_back.sv
// ----------------------------------------------------------------------------
// artdmx_back
// Address stage: turns queued commands into result items. Holds the image
// base register, forms universe * pixels per universe + index, then adds the
// base into the output register.
// ----------------------------------------------------------------------------
module artdmx_back #(
	parameter int PIXELS_PER_UNIVERSE = artdmx_pkg::PIXELS_PER_UNIVERSE_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [artdmx_pkg::ADDR_W-1:0] cfg_wdata,
	input  logic                         queue_empty,
	input  artdmx_pkg::cmd_t             head,
	output logic                         pop,
	artdmx_result_if.source              results
);
	import artdmx_pkg::*;

	logic [ADDR_W-1:0]   image_base_q;

	logic                valid_s1;
	kind_t               kind_s1;
	err_code_t           code_s1;
	logic [RGB_W-1:0]    rgb_s1;
	logic [OFFSET_W-1:0] offset_s1;

	logic                valid_s2;
	kind_t               kind_s2;
	err_code_t           code_s2;
	logic [RGB_W-1:0]    rgb_s2;
	logic [ADDR_W-1:0]   address_s2;

	logic                adv_s1;
	logic                adv_s2;
	logic [OFFSET_W-1:0] offset;

	assign adv_s2 = !valid_s2 || results.ready;
	assign adv_s1 = !valid_s1 || adv_s2;
	assign pop    = adv_s1 && !queue_empty;
	assign offset = OFFSET_W'(head.universe) * OFFSET_W'(PIXELS_PER_UNIVERSE)
		+ OFFSET_W'(head.pixel_index);

	// Image base register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_base_q <= '0;
		end else if (cfg_we) begin
			image_base_q <= cfg_wdata;
		end
	end

	// Stage valid flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1) begin
				valid_s1 <= !queue_empty;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// Stage one: pixel offset within the image.
	always_ff @(posedge clk) begin
		if (adv_s1) begin
			kind_s1   <= head.kind;
			code_s1   <= head.code;
			rgb_s1    <= head.rgb;
			offset_s1 <= offset;
		end
	end

	// Stage two: output register; error items carry zero address and color.
	always_ff @(posedge clk) begin
		if (adv_s2) begin
			kind_s2 <= kind_s1;
			if (kind_s1 == KIND_PIXEL) begin
				code_s2    <= ERR_SYNC;
				rgb_s2     <= rgb_s1;
				address_s2 <= image_base_q + ADDR_W'(offset_s1);
			end else begin
				code_s2    <= code_s1;
				rgb_s2     <= '0;
				address_s2 <= '0;
			end
		end
	end

	assign results.valid         = valid_s2;
	assign results.result_kind   = kind_s2;
	assign results.write_address = address_s2;
	assign results.pixel_rgb     = rgb_s2;
	assign results.error_code    = code_s2;

`ifndef ASSERT_OFF
	// An error item never carries an address or a color.
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && kind_s2 == KIND_ERROR) |-> (address_s2 == '0 && rgb_s2 == '0))
		else $error("error item with nonzero payload");

	// A pixel item always carries a zero error code.
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && kind_s2 == KIND_PIXEL) |-> (code_s2 == ERR_SYNC))
		else $error("pixel item with nonzero error code");

	// A held stage one item is not dropped while the output stalls.
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !adv_s1) |=> valid_s1)
		else $error("stage one item lost during stall");
`endif

endmodule

### design/artdmx_pixel_stream_parser_unit.sv
// ----------------------------------------------------------------------------
// artdmx_pixel_stream_parser_unit
// ArtDmx pixel stream parser: received bytes in, pixel writes and error
// reports out.
// ----------------------------------------------------------------------------
// The block takes one received byte per cycle while input ready is high and
// produces at most one result item per byte. A byte is parsed in the cycle it
// is accepted and its command enters a four-entry queue; the address stage
// then registers the offset multiply and adds the base into the output
// register. Input ready drops only when the queue is full, which happens
// only after the result side has stalled.
// Pixel writes go to image_base + universe * PIXELS_PER_UNIVERSE + index;
// header faults are reported at the last byte of the frame, sync and
// oversize faults at once. Write image_base only while the block is idle.
module artdmx_pixel_stream_parser_unit #(
	parameter int PIXELS_PER_UNIVERSE = artdmx_pkg::PIXELS_PER_UNIVERSE_DEF,
	parameter int MAX_FRAME_BYTES     = artdmx_pkg::MAX_FRAME_BYTES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	artdmx_byte_if.sink                   bytes,
	artdmx_result_if.source               results,
	input  logic                          cfg_we,
	input  logic [artdmx_pkg::ADDR_W-1:0] cfg_wdata
);
	import artdmx_pkg::*;

	cmd_t cmd;
	cmd_t head;
	logic cmd_push;
	logic pop;
	logic queue_full;
	logic queue_empty;

	// Byte parser.
	artdmx_front #(
		.MAX_FRAME_BYTES (MAX_FRAME_BYTES)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.bytes      (bytes),
		.queue_full (queue_full),
		.cmd_push   (cmd_push),
		.cmd        (cmd)
	);

	// Command queue.
	artdmx_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (cmd_push),
		.wdata  (cmd),
		.pop    (pop),
		.rdata  (head),
		.full   (queue_full),
		.empty  (queue_empty)
	);

	// Address stage and output register.
	artdmx_back #(
		.PIXELS_PER_UNIVERSE (PIXELS_PER_UNIVERSE)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.queue_empty (queue_empty),
		.head        (head),
		.pop         (pop),
		.results     (results)
	);

endmodule
